// File: rtl/rmcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmcc_pkg;

  localparam int unsigned NumRefs         = 7;
  localparam int unsigned ChanW           = 8;
  localparam int unsigned RefW            = 3 * ChanW;
  localparam int unsigned SumW            = 20;
  localparam int unsigned CntW            = 13;
  localparam int unsigned MaxRegionPixels = 4096;
  localparam int unsigned DistBound       = 10000;
  localparam int unsigned DistW           = 18;
  localparam int unsigned AddrW           = 5;
  localparam int unsigned DataW           = 32;

  typedef enum logic [2:0] {
    REG_DARK    = 3'd0,
    REG_UNKNOWN = 3'd1,
    REG_BLUE    = 3'd2,
    REG_GREEN   = 3'd3,
    REG_ORANGE  = 3'd4,
    REG_RED     = 3'd5,
    REG_WHITE   = 3'd6,
    REG_YELLOW  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    COLOR_UNKNOWN = 3'd0,
    COLOR_BLUE    = 3'd1,
    COLOR_GREEN   = 3'd2,
    COLOR_ORANGE  = 3'd3,
    COLOR_RED     = 3'd4,
    COLOR_WHITE   = 3'd5,
    COLOR_YELLOW  = 3'd6
  } color_e;

  localparam logic [ChanW-1:0] DarkLevelRst = 8'd70;

  // Packed as ch2 in the top byte, ch0 in the bottom byte.
  localparam logic [RefW-1:0] RefRst [NumRefs] = '{
    24'h4B4B4B, 24'h328CFA, 24'h00CD23, 24'hFA8200,
    24'hFA0000, 24'hF0F0F0, 24'hE6E600
  };

  typedef struct packed {
    logic [ChanW-1:0]              dark_level;
    logic [NumRefs-1:0][RefW-1:0]  refs;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/rmcc_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rmcc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  logic       region_end;

  modport source (output valid, chan0, chan1, chan2, region_end, input ready);
  modport sink (input valid, chan0, chan1, chan2, region_end, output ready);
endinterface

`default_nettype wire

// File: rtl/rmcc_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rmcc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] color_code;
  logic [7:0] mean0;
  logic [7:0] mean1;
  logic [7:0] mean2;

  modport source (output valid, color_code, mean0, mean1, mean2, input ready);
  modport sink (input valid, color_code, mean0, mean1, mean2, output ready);
endinterface

`default_nettype wire

// File: rtl/rmcc_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rmcc_regs import rmcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [ChanW-1:0] dark_q;
  logic [RefW-1:0]  refs_q [NumRefs];
  reg_idx_e         idx;
  logic [2:0]       ref_sel;
  logic             wr_en;

  assign idx     = reg_idx_e'(paddr[AddrW-1:2]);
  assign ref_sel = 3'(idx) - 3'd1;
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q <= DarkLevelRst;
      for (int k = 0; k < NumRefs; k++) begin
        refs_q[k] <= RefRst[k];
      end
    end else if (wr_en) begin
      if (idx == REG_DARK) begin
        dark_q <= pwdata[ChanW-1:0];
      end else begin
        refs_q[ref_sel] <= pwdata[RefW-1:0];
      end
    end
  end

  always_comb begin
    if (idx == REG_DARK) begin
      prdata = DataW'(dark_q);
    end else begin
      prdata = DataW'(refs_q[ref_sel]);
    end
  end

  always_comb begin
    cfg_o.dark_level = dark_q;
    for (int k = 0; k < NumRefs; k++) begin
      cfg_o.refs[k] = refs_q[k];
    end
  end

endmodule

`default_nettype wire

// File: rtl/region_mean_color_classifier.sv
// Pixels that do not end a region are taken one per cycle.
// A region-end word runs one shared subtract/compare and one 8x8 multiplier through
// restoring division of each channel sum (ST_DIV), then distance accumulation over
// every channel of every reference (ST_CLS, cut short if dark), then loads the output
// register (ST_OUT); input is held off until then, longer while a previous result stalls.
// Reset (rst_ni low, asynchronous) clears sums, count and handshake, and loads defaults.
`timescale 1ns / 1ps
`default_nettype none

module region_mean_color_classifier import rmcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  rmcc_pix_if.sink         in_i,
  rmcc_res_if.source       out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_CLS  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  cfg_t cfg;

  rmcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e           state_q;
  logic [SumW-1:0]  sum_q [3];
  logic [CntW-1:0]  cnt_q;
  logic [1:0]       chan_q;
  logic [2:0]       bit_q;
  logic [2:0]       refi_q;
  logic [SumW-1:0]  rem_q;
  logic [ChanW-1:0] mean_q [3];
  logic [DistW-1:0] acc_q;
  logic [DistW-1:0] best_q;
  color_e           code_q;
  logic             out_valid_q;
  logic [2:0]       out_code_q;
  logic [ChanW-1:0] out_mean_q [3];

  logic             in_acc;
  logic             room;
  logic [SumW-1:0]  rem_in;
  logic [SumW-1:0]  dsr;
  logic [SumW:0]    trial;
  logic             fit;
  logic [ChanW-1:0] m_sel;
  logic [ChanW-1:0] r_sel;
  logic [ChanW-1:0] diff;
  logic [2*ChanW-1:0] sq;
  logic [DistW-1:0] dist_sum;
  logic             dark;
  logic             out_free;
  logic             out_load;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign room       = (cnt_q < CntW'(MaxRegionPixels));
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == ST_OUT) && out_free;

  // Restoring division: the quotient always fits 8 bits because every
  // channel sum is below 256 times the count.
  assign rem_in = (bit_q == 3'd7) ? sum_q[chan_q] : rem_q;
  assign dsr    = SumW'(cnt_q) << bit_q;
  assign trial  = {1'b0, rem_in} - {1'b0, dsr};
  assign fit    = !trial[SumW];

  // One channel of one reference distance per cycle.
  assign m_sel    = mean_q[chan_q];
  assign r_sel    = cfg.refs[refi_q][{chan_q, 3'b000} +: ChanW];
  assign diff     = (m_sel >= r_sel) ? (m_sel - r_sel) : (r_sel - m_sel);
  assign sq       = diff * diff;
  assign dist_sum = acc_q + DistW'(sq);
  assign dark     = (mean_q[0] < cfg.dark_level) && (mean_q[1] < cfg.dark_level) &&
                    (mean_q[2] < cfg.dark_level);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
      cnt_q       <= '0;
      chan_q      <= '0;
      bit_q       <= 3'd7;
      refi_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (room) begin
              sum_q[0] <= sum_q[0] + SumW'(in_i.chan0);
              sum_q[1] <= sum_q[1] + SumW'(in_i.chan1);
              sum_q[2] <= sum_q[2] + SumW'(in_i.chan2);
              cnt_q    <= cnt_q + CntW'(1);
            end
            if (in_i.region_end) begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          bit_q <= bit_q - 3'd1;
          if (bit_q == 3'd0) begin
            if (chan_q == 2'd2) begin
              chan_q   <= '0;
              refi_q   <= '0;
              sum_q[0] <= '0;
              sum_q[1] <= '0;
              sum_q[2] <= '0;
              cnt_q    <= '0;
              state_q  <= ST_CLS;
            end else begin
              chan_q <= chan_q + 2'd1;
            end
          end
        end
        ST_CLS: begin
          if (refi_q == 3'd0 && chan_q == 2'd0 && dark) begin
            state_q <= ST_OUT;
          end else if (chan_q == 2'd2) begin
            chan_q <= '0;
            if (refi_q == 3'(NumRefs - 1)) begin
              refi_q  <= '0;
              state_q <= ST_OUT;
            end else begin
              refi_q <= refi_q + 3'd1;
            end
          end else begin
            chan_q <= chan_q + 2'd1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV) begin
      rem_q                 <= fit ? trial[SumW-1:0] : rem_in;
      mean_q[chan_q][bit_q] <= fit;
      acc_q                 <= '0;
      best_q                <= DistW'(DistBound);
      code_q                <= COLOR_UNKNOWN;
    end
    if (state_q == ST_CLS) begin
      if (chan_q == 2'd2) begin
        acc_q <= '0;
        if (dist_sum < best_q) begin
          best_q <= dist_sum;
          code_q <= color_e'(refi_q);
        end
      end else begin
        acc_q <= dist_sum;
      end
    end
    if (out_load) begin
      out_code_q    <= code_q;
      out_mean_q[0] <= mean_q[0];
      out_mean_q[1] <= mean_q[1];
      out_mean_q[2] <= mean_q[2];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.color_code = out_code_q;
  assign out_o.mean0      = out_mean_q[0];
  assign out_o.mean1      = out_mean_q[1];
  assign out_o.mean2      = out_mean_q[2];

endmodule

`default_nettype wire

// File: rtl/rmcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rmcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_code_i
);

  // A region end word starts the sequencer, so input is held off next cycle.
  a_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input still ready after region end");

  // A plain pixel word is summed (unless the region limit is reached) and input stays open in the next cycle.
  a_pixel_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=> in_ready_i)
    else $error("input stalled after a plain pixel");

  // A new result is only loaded at the end of a busy sequence.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a classification pass");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_code_i))
    else $error("stalled result word changed");

endmodule

bind region_mean_color_classifier rmcc_checker u_rmcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.region_end),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_code_i  (out_o.color_code)
);

`default_nettype wire

// File: bench/rmcc_mean_checker.sv
`timescale 1ns / 1ps

module rmcc_mean_checker import rmcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  rmcc_pix_if                pix_i,
  rmcc_res_if                res_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  input  logic [DataW-1:0]   prdata,
  input  logic               pready,
  output int unsigned        errors_o,
  output int unsigned        pending_o,
  output int unsigned        regions_o,
  output logic [NumRefs-1:0] codes_seen_o
);

  typedef struct packed {
    color_e           code;
    logic [ChanW-1:0] mean0;
    logic [ChanW-1:0] mean1;
    logic [ChanW-1:0] mean2;
  } region_color_t;

  logic [ChanW-1:0]   dark_level;
  logic [RefW-1:0]    ref_colors [NumRefs];
  logic [SumW-1:0]    sum0, sum1, sum2;
  logic [CntW-1:0]    pixels;
  region_color_t      expected_colors [$];
  int unsigned        errors, regions;
  logic [NumRefs-1:0] seen;

  // Mean color of the region so far, then, unless it is dark, nearest reference within the bound.
  function automatic region_color_t classify_region();
    region_color_t r;
    int unsigned   best, dist_sum;
    int            d0, d1, d2, k;
    r.code  = COLOR_UNKNOWN;
    r.mean0 = '0;
    r.mean1 = '0;
    r.mean2 = '0;
    if (pixels != 0) begin
      r.mean0 = ChanW'(sum0 / SumW'(pixels));
      r.mean1 = ChanW'(sum1 / SumW'(pixels));
      r.mean2 = ChanW'(sum2 / SumW'(pixels));
    end
    best = DistBound;
    if (!(r.mean0 < dark_level && r.mean1 < dark_level && r.mean2 < dark_level)) begin
      for (k = 0; k < NumRefs; k++) begin
        d0       = int'(r.mean0) - int'(ref_colors[k][ChanW-1:0]);
        d1       = int'(r.mean1) - int'(ref_colors[k][2*ChanW-1:ChanW]);
        d2       = int'(r.mean2) - int'(ref_colors[k][RefW-1:2*ChanW]);
        dist_sum = d0 * d0 + d1 * d1 + d2 * d2;
        // Strictly smaller only, so the earlier reference keeps a tie.
        if (dist_sum < best) begin
          best   = dist_sum;
          r.code = color_e'(k);
        end
      end
    end
    return r;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    region_color_t    want;
    reg_idx_e         reg_sel;
    logic [DataW-1:0] want_word;
    if (!rst_ni) begin
      dark_level = DarkLevelRst;
      for (int i = 0; i < NumRefs; i++) ref_colors[i] = RefRst[i];
      sum0    = '0;
      sum1    = '0;
      sum2    = '0;
      pixels  = '0;
      errors  = 0;
      regions = 0;
      seen    = '0;
      expected_colors.delete();
    end else begin
      if (psel && penable && pready) begin
        reg_sel = reg_idx_e'(paddr[AddrW-1:2]);
        if (pwrite) begin
          if (reg_sel == REG_DARK) dark_level = pwdata[ChanW-1:0];
          else ref_colors[reg_sel - 1] = pwdata[RefW-1:0];
        end else begin
          want_word = (reg_sel == REG_DARK) ? DataW'(dark_level)
                                            : DataW'(ref_colors[reg_sel - 1]);
          if (prdata !== want_word) begin
            errors++;
            $error("prdata of register %0d: expected %h, got %h", reg_sel, want_word, prdata);
          end
        end
      end

      if (res_i.valid && res_i.ready) begin
        if (expected_colors.size() == 0) begin
          errors++;
          $error("result word with no region pending: color_code %0d", res_i.color_code);
        end else begin
          want = expected_colors.pop_front();
          regions++;
          seen[want.code] = 1'b1;
          compare_field("color_code", 8'(want.code), 8'(res_i.color_code));
          compare_field("mean0", want.mean0, res_i.mean0);
          compare_field("mean1", want.mean1, res_i.mean1);
          compare_field("mean2", want.mean2, res_i.mean2);
        end
      end

      if (pix_i.valid && pix_i.ready) begin
        // Pixels past the region limit are dropped, the last one included.
        if (pixels < CntW'(MaxRegionPixels)) begin
          sum0 += pix_i.chan0;
          sum1 += pix_i.chan1;
          sum2 += pix_i.chan2;
          pixels++;
        end
        if (pix_i.region_end) begin
          expected_colors.push_back(classify_region());
          sum0   = '0;
          sum1   = '0;
          sum2   = '0;
          pixels = '0;
        end
      end
    end
    errors_o     <= errors;
    pending_o    <= expected_colors.size();
    regions_o    <= regions;
    codes_seen_o <= seen;
  end

endmodule

// File: bench/region_mean_color_classifier_test.sv
`timescale 1ns / 1ps

module region_mean_color_classifier_test;
  import rmcc_pkg::*;

  localparam int unsigned ItemsPerPhase = 275;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned SettleCycles  = 60;
  localparam int unsigned IdleLimit     = 2000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;

  rmcc_pix_if pix_if ();
  rmcc_res_if res_if ();

  int unsigned        errors, pending, regions;
  logic [NumRefs-1:0] codes_seen;
  int unsigned        pixels_sent;
  int unsigned        idle_cycles;
  bit                 steady;
  logic [ChanW-1:0]   cur_dark;
  logic [RefW-1:0]    cur_refs [NumRefs];
  logic [RefW-1:0]    focus;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  region_mean_color_classifier u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pix_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rmcc_mean_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_if),
    .res_i        (res_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .errors_o     (errors),
    .pending_o    (pending),
    .regions_o    (regions),
    .codes_seen_o (codes_seen)
  );

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady || roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Pixel within +/- spread of a base color on every channel, clamped.
  function automatic logic [RefW-1:0] near(logic [RefW-1:0] base, int spread);
    logic [RefW-1:0] px;
    int              v, c;
    for (c = 0; c < 3; c++) begin
      v = int'(base[c*ChanW +: ChanW]) + int'($urandom_range(2 * spread, 0)) - spread;
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      px[c*ChanW +: ChanW] = ChanW'(v);
    end
    return px;
  endfunction

  task automatic cfg_write(input reg_idx_e idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DARK) cur_dark = value[ChanW-1:0];
    else cur_refs[idx - 1] = value[RefW-1:0];
  endtask

  task automatic cfg_read(input reg_idx_e idx);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_pixel(input logic [RefW-1:0] px, input bit last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid      <= 1'b1;
    pix_if.chan0      <= px[ChanW-1:0];
    pix_if.chan1      <= px[2*ChanW-1:ChanW];
    pix_if.chan2      <= px[RefW-1:2*ChanW];
    pix_if.region_end <= last;
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
  endtask

  // Holds off the pixel stream until every region has come back.
  task automatic drain(input int unsigned settle);
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic send_region(input int unsigned len);
    int unsigned     mode, n, c;
    int              spread;
    logic [RefW-1:0] base, px;
    mode   = $urandom_range(99);
    spread = $urandom_range(40, 0);
    base   = ($urandom_range(4) == 0) ? focus : cur_refs[$urandom_range(NumRefs - 1)];
    if (mode >= 60 && mode < 75) begin
      base   = {3{cur_dark}};
      spread = 4;
    end
    for (n = 1; n <= len; n++) begin
      if (mode < 75) begin
        px = near(base, spread);
      end else if (mode < 85) begin
        for (c = 0; c < 3; c++) px[c*ChanW +: ChanW] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      end else begin
        px = RefW'($urandom());
      end
      send_pixel(px, n == len);
    end
  endtask

  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("region_mean_color_classifier_test: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned     p, i, target, len, roll;
    logic [RefW-1:0] x;
    idle_cycles        = 0;
    pixels_sent        = 0;
    steady             = 1'b0;
    cur_dark           = DarkLevelRst;
    for (i = 0; i < NumRefs; i++) cur_refs[i] = RefRst[i];
    focus              = RefRst[0];
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    pix_if.valid      <= 1'b0;
    pix_if.chan0      <= '0;
    pix_if.chan1      <= '0;
    pix_if.chan2      <= '0;
    pix_if.region_end <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i <= NumRefs; i++) cfg_read(reg_idx_e'(i));

    // Black and white single pixels, then a two-pixel region averaging to gray.
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'hFF00FF, 1'b0);
    send_pixel(24'h00FF00, 1'b1);
    for (i = 0; i < NumRefs; i++) send_pixel(RefRst[i], 1'b1);
    // Far from every reference, so nothing lies within the bound.
    send_pixel(24'h0000FF, 1'b1);
    // Just below the dark level on all channels, then one channel at it.
    send_pixel(24'h454545, 1'b1);
    send_pixel(24'h454546, 1'b1);
    // Sums that do not divide evenly by the count.
    send_pixel(24'hC8140A, 1'b0);
    send_pixel(24'hC9140B, 1'b0);
    send_pixel(24'hC9150B, 1'b1);

    for (p = 0; p < NumPhases; p++) begin
      drain(SettleCycles);
      case (p)
        0: begin
          cfg_write(REG_DARK, '0);
          for (i = 1; i <= NumRefs; i++) cfg_write(reg_idx_e'(i), $urandom() & 32'hFF_FFFF);
        end
        1: begin
          cfg_write(REG_DARK, 32'hFF);
          for (i = 1; i <= NumRefs; i++)
            cfg_write(reg_idx_e'(i), (i % 2 != 0) ? 32'hFF_FFFF : 32'h0);
        end
        2: begin
          // Several references equally far from one point; the lowest code must win.
          x = {8'($urandom_range(235, 20)), 8'($urandom_range(235, 20)),
               8'($urandom_range(235, 20))};
          cfg_write(REG_DARK, $urandom_range(100));
          cfg_write(REG_UNKNOWN, 32'hFF_FFFF);
          cfg_write(REG_BLUE, DataW'(x + 24'h00000A));
          cfg_write(REG_GREEN, DataW'(x - 24'h00000A));
          cfg_write(REG_ORANGE, DataW'(x + 24'h00000A));
          cfg_write(REG_RED, DataW'(x + 24'h000A00));
          cfg_write(REG_WHITE, $urandom() & 32'hFF_FFFF);
          cfg_write(REG_YELLOW, $urandom() & 32'hFF_FFFF);
          focus = x;
        end
        3: begin
          // Upper data bits set on purpose; the registers keep only their width.
          cfg_write(REG_DARK, $urandom());
          for (i = 1; i <= NumRefs; i++) cfg_write(reg_idx_e'(i), $urandom());
        end
        4: begin
          cfg_write(REG_DARK, DataW'(DarkLevelRst));
          for (i = 1; i <= NumRefs; i++) cfg_write(reg_idx_e'(i), DataW'(RefRst[i-1]));
        end
        default: begin
          cfg_write(REG_DARK, $urandom_range(255));
          for (i = 1; i <= NumRefs; i++) cfg_write(reg_idx_e'(i), $urandom() & 32'hFF_FFFF);
        end
      endcase
      for (i = 0; i <= NumRefs; i++) cfg_read(reg_idx_e'(i));
      if (p != 2) focus = cur_refs[$urandom_range(NumRefs - 1)];

      target = pixels_sent + ItemsPerPhase;
      while (pixels_sent < target) begin
        if ($urandom_range(39) == 0) steady = !steady;
        if ($urandom_range(49) == 0) drain(0);
        roll = $urandom_range(99);
        if (roll < 80) len = $urandom_range(6, 1);
        else if (roll < 96) len = $urandom_range(40, 7);
        else len = $urandom_range(200, 41);
        send_region(len);
      end
    end
    drain(SettleCycles);

    $display("Sent %0d pixels; %0d regions classified under %0d register settings.",
             pixels_sent, regions, NumPhases + 1);
    $display("Color codes seen, yellow down to unknown: %b", codes_seen);
    if (errors == 0) begin
      $display("region_mean_color_classifier_test: done, clean");
    end else begin
      $display("region_mean_color_classifier_test: done, errors");
    end
    $finish;
  end

endmodule
